/* rtl/stabilizer_tableau_gate_engine_top_macros.svh */
// Assertion macros shared by the tableau engine modules.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef STABILIZER_TABLEAU_GATE_ENGINE_TOP_MACROS_SVH
`define STABILIZER_TABLEAU_GATE_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define STG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/stg_pkg.sv */
// Shared types and constants of the stabilizer tableau gate engine.
// No dependencies; used by the channel interfaces and all modules.
package stg_pkg;

	localparam int unsigned KIND_W  = 4;
	localparam int unsigned QUBIT_W = 5;
	localparam int unsigned SEL_W   = 6;
	localparam int unsigned NQ_W    = 6;
	localparam int unsigned ROW_W   = 64;

	typedef enum logic [KIND_W-1:0] {
		KIND_INIT       = 4'd0,
		KIND_X          = 4'd1,
		KIND_Y          = 4'd2,
		KIND_Z          = 4'd3,
		KIND_S          = 4'd4,
		KIND_SDAG       = 4'd5,
		KIND_H          = 4'd6,
		KIND_CNOT       = 4'd7,
		KIND_READ_COL   = 4'd8,
		KIND_READ_PHASE = 4'd9
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture the accepted item
		logic init_apply; // reload identity
		logic rd_t;       // read target columns (or the selected column)
		logic rd_c;       // capture target words, read control columns
		logic exec;       // phase update and first column write
		logic wr2;        // second column write
		logic out_load;   // load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic err;
		logic is_init;
		logic is_read_col;
		logic is_read_phase;
		logic two_writes;
		logic out_busy;
	} status_t;

endpackage

/* rtl/stg_channels.sv */
// Valid/ready channel interfaces: gate items in, results out, qubit count writes.
// Depends on stg_pkg.
interface stg_req_if;
	import stg_pkg::*;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [QUBIT_W-1:0] target_qubit;
	logic [QUBIT_W-1:0] control_qubit;
	logic [SEL_W-1:0]   column_select;
	modport source(output valid, kind, target_qubit, control_qubit, column_select,
		input ready);
	modport sink(input valid, kind, target_qubit, control_qubit, column_select,
		output ready);
endinterface

interface stg_rsp_if;
	import stg_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] read_data;
	logic             error;
	modport source(output valid, read_data, error, input ready);
	modport sink(input valid, read_data, error, output ready);
endinterface

interface stg_cfg_if;
	import stg_pkg::*;
	logic            valid;
	logic            ready;
	logic [NQ_W-1:0] qubits_in_use;
	modport source(output valid, qubits_in_use, input ready);
	modport sink(input valid, qubits_in_use, output ready);
endinterface

/* rtl/stg_datapath.sv */
// Tableau datapath: column memory with valid bits, phase word, gate updates,
// item decode and the result register. Depends on stg_pkg and the macro header.
`include "stabilizer_tableau_gate_engine_top_macros.svh"

module stg_datapath #(
	parameter int MAX_QUBITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [stg_pkg::NQ_W-1:0]      cfg_data,
	input  logic [stg_pkg::KIND_W-1:0]    kind,
	input  logic [stg_pkg::QUBIT_W-1:0]   target_qubit,
	input  logic [stg_pkg::QUBIT_W-1:0]   control_qubit,
	input  logic [stg_pkg::SEL_W-1:0]     column_select,
	input  stg_pkg::cmd_t                 cmd,
	output stg_pkg::status_t              sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [stg_pkg::ROW_W-1:0]     read_data,
	output logic                          error
);
	import stg_pkg::*;

	localparam int COLS   = 2 * MAX_QUBITS;
	localparam int CIDX_W = (COLS > 1) ? $clog2(COLS) : 1;

	function automatic logic [ROW_W-1:0] col_word(input logic [ROW_W-1:0] d,
		input logic v, input logic [CIDX_W-1:0] a);
		col_word = v ? d : (ROW_W'(1) << a);
	endfunction

	logic [NQ_W-1:0]    qubits_q;
	logic [NQ_W-1:0]    n_eff;
	logic [KIND_W-1:0]  kind_q;
	logic [QUBIT_W-1:0] t_q, c_q;
	logic [SEL_W-1:0]   sel_q;
	kind_t              kind_e;

	logic [NQ_W-1:0]    zt6, zc6;
	logic [CIDX_W-1:0]  xt_i, zt_i, xc_i, zc_i, sel_i;
	logic               t_bad, c_bad, sel_bad;

	logic [ROW_W-1:0]   mem_q [COLS];
	logic [COLS-1:0]    valid_q;
	logic [ROW_W-1:0]   rd0_q, rd1_q;
	logic               rv0_q, rv1_q;
	logic [CIDX_W-1:0]  ra0_q, ra1_q;
	logic [CIDX_W-1:0]  ra0, ra1;

	logic [ROW_W-1:0]   xw_q, zw_q, w2_data_q;
	logic [ROW_W-1:0]   xcw, zcw, phase_q, phase_delta;
	logic               we;
	logic [CIDX_W-1:0]  wa;
	logic [ROW_W-1:0]   wd;

	logic               out_valid_q, out_err_q;
	logic [ROW_W-1:0]   out_data_q, res_data;

	// qubit count register; the effective count is clamped to 1..MAX_QUBITS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qubits_q <= NQ_W'(32);
		end else if (cfg_we) begin
			qubits_q <= cfg_data;
		end
	end

	always_comb begin
		if (qubits_q == '0) begin
			n_eff = NQ_W'(1);
		end else if (qubits_q > NQ_W'(MAX_QUBITS)) begin
			n_eff = NQ_W'(MAX_QUBITS);
		end else begin
			n_eff = qubits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_INIT;
			t_q    <= '0;
			c_q    <= '0;
			sel_q  <= '0;
		end else if (cmd.latch) begin
			kind_q <= kind;
			t_q    <= target_qubit;
			c_q    <= control_qubit;
			sel_q  <= column_select;
		end
	end

	assign kind_e = kind_t'(kind_q);
	assign zt6    = {1'b0, t_q} + n_eff;
	assign zc6    = {1'b0, c_q} + n_eff;
	assign xt_i   = CIDX_W'(t_q);
	assign xc_i   = CIDX_W'(c_q);
	assign zt_i   = zt6[CIDX_W-1:0];
	assign zc_i   = zc6[CIDX_W-1:0];
	assign sel_i  = sel_q[CIDX_W-1:0];

	assign t_bad   = {1'b0, t_q} >= n_eff;
	assign c_bad   = ({1'b0, c_q} >= n_eff) || (c_q == t_q);
	assign sel_bad = {1'b0, sel_q} >= {n_eff, 1'b0};

	always_comb begin
		sts = '0;
		unique case (kind_e)
			KIND_INIT:       sts.is_init = 1'b1;
			KIND_X, KIND_Y, KIND_Z, KIND_S, KIND_SDAG:
				sts.err = t_bad;
			KIND_H: begin
				sts.err        = t_bad;
				sts.two_writes = 1'b1;
			end
			KIND_CNOT: begin
				sts.err        = t_bad || c_bad;
				sts.two_writes = 1'b1;
			end
			KIND_READ_COL: begin
				sts.err         = sel_bad;
				sts.is_read_col = 1'b1;
			end
			KIND_READ_PHASE: sts.is_read_phase = 1'b1;
			default:         sts.err = 1'b1;
		endcase
		sts.out_busy = out_valid_q && !out_ready;
	end

	// read addresses
	always_comb begin
		if (cmd.rd_t) begin
			ra0 = (kind_e == KIND_READ_COL) ? sel_i : xt_i;
			ra1 = zt_i;
		end else begin
			ra0 = xc_i;
			ra1 = zc_i;
		end
	end

	// column memory, registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd0_q <= mem_q[ra0];
		rd1_q <= mem_q[ra1];
		rv0_q <= valid_q[ra0];
		rv1_q <= valid_q[ra1];
		ra0_q <= ra0;
		ra1_q <= ra1;
	end

	// an entry not written since init reads as its identity column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.init_apply) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[wa] <= 1'b1;
		end
	end

	assign xcw = col_word(rd0_q, rv0_q, ra0_q);
	assign zcw = col_word(rd1_q, rv1_q, ra1_q);

	always_ff @(posedge clk) begin
		if (cmd.rd_c) begin
			xw_q <= xcw;
			zw_q <= zcw;
		end
		if (cmd.exec) begin
			w2_data_q <= (kind_e == KIND_H) ? xw_q : (zcw ^ zw_q);
		end
	end

	always_comb begin
		phase_delta = '0;
		we          = 1'b0;
		wa          = xt_i;
		wd          = xw_q ^ xcw;
		if (cmd.wr2) begin
			we = 1'b1;
			wa = (kind_e == KIND_H) ? zt_i : zc_i;
			wd = w2_data_q;
		end else if (cmd.exec) begin
			unique case (kind_e)
				KIND_X: phase_delta = zw_q;
				KIND_Y: phase_delta = zw_q ^ xw_q;
				KIND_Z: phase_delta = xw_q;
				KIND_S, KIND_SDAG: begin
					phase_delta = (kind_e == KIND_S) ? (xw_q & zw_q) : (xw_q & ~zw_q);
					we = 1'b1;
					wa = zt_i;
					wd = zw_q ^ xw_q;
				end
				KIND_H: begin
					phase_delta = xw_q & zw_q;
					we = 1'b1;
					wa = xt_i;
					wd = zw_q;
				end
				KIND_CNOT: begin
					phase_delta = xcw & zw_q & ~(xw_q ^ zcw);
					we = 1'b1;
					wa = xt_i;
					wd = xw_q ^ xcw;
				end
				default: phase_delta = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.init_apply) begin
			phase_q <= '0;
		end else if (cmd.exec) begin
			phase_q <= phase_q ^ phase_delta;
		end
	end

	// result register
	always_comb begin
		if (sts.is_read_col && !sts.err) begin
			res_data = xw_q;
		end else if (sts.is_read_phase) begin
			res_data = phase_q;
		end else begin
			res_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= res_data;
			out_err_q  <= sts.err;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_data_q;
	assign error     = out_err_q;

	`STG_ASSERT_IMP(a_err_no_data, out_valid_q && out_err_q, out_data_q == '0,
		"rejected item carries nonzero data")
	`STG_ASSERT_IMP(a_single_write, cmd.exec && cmd.wr2, 1'b0,
		"two column writes in one cycle")
	`STG_ASSERT_NXT(a_out_hold, out_valid_q && !out_ready, out_valid_q,
		"result dropped while stalled")

endmodule

/* rtl/stg_ctrl.sv */
// Item sequencer of the tableau engine: one-hot state machine issuing datapath
// commands. Depends on stg_pkg and the macro header.
`include "stabilizer_tableau_gate_engine_top_macros.svh"

module stg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  stg_pkg::status_t sts,
	output stg_pkg::cmd_t    cmd
);
	import stg_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECODE = 7'b0000010,
		ST_RD_T   = 7'b0000100,
		ST_RD_C   = 7'b0001000,
		ST_EXEC   = 7'b0010000,
		ST_WR2    = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.init_apply = sts.is_init;
				if (sts.err || sts.is_init || sts.is_read_phase) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_RD_T;
				end
			end
			ST_RD_T: begin
				cmd.rd_t = 1'b1;
				state_d  = ST_RD_C;
			end
			ST_RD_C: begin
				cmd.rd_c = 1'b1;
				state_d  = sts.is_read_col ? ST_DONE : ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.two_writes ? ST_WR2 : ST_DONE;
			end
			ST_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.out_load = !sts.out_busy;
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	`STG_ASSERT_NXT(a_accept_decode, in_valid && state_q == ST_IDLE,
		state_q == ST_DECODE, "accepted item not decoded next cycle")
	`STG_ASSERT_IMP(a_load_free, cmd.out_load, !sts.out_busy,
		"result loaded over an untaken result")
	`STG_ASSERT_IMP(a_wr2_after_exec, state_q == ST_WR2, $past(state_q) == ST_EXEC,
		"second write not preceded by execute")

endmodule

/* rtl/stabilizer_tableau_gate_engine_top.sv */
// Stabilizer tableau gate engine, top level: channels, sequencer and datapath.
// Depends on stg_pkg, stg_channels, stg_ctrl and stg_datapath.
//
// Holds a Clifford stabilizer tableau as 2*MAX_QUBITS column words of 64 row
// bits (X columns of qubits 0..n-1, then Z columns) plus a 64-bit phase word,
// where n is the qubits_in_use register clamped to 1..MAX_QUBITS (0 acts as 1).
// Each item on req applies X, Y, Z, S, Sdag, H or CNOT, reloads the identity
// tableau, or reads a column or the phase word; every item returns exactly one
// item on rsp. Bad qubit indices, CNOT with control equal to target, a column
// select at or above 2n, and unknown kinds return error=1, data 0, no change.
// Writing qubits_in_use does not touch the tableau; send an init item after.
// Columns live in a single-write, dual-read memory with registered reads; a
// valid bit per column makes init take effect at once (unwritten columns read
// as identity), so there is no clearing pass after reset. One item at a time:
// init, read phase and rejected items go from decode to done; a column read adds
// both read steps, X/Y/Z/S/Sdag then execute, and H or CNOT write twice, because
// the two target columns, then the two control columns, are read through the two
// memory ports and the updated columns go back through the one write port.
// A finished result waits in the output register while the next item is taken.
// The cfg channel is always ready and must only be written while idle.
module stabilizer_tableau_gate_engine_top #(
	parameter int MAX_QUBITS = 32
) (
	input logic      clk,
	input logic      arst_n,
	stg_cfg_if.sink  cfg,
	stg_req_if.sink  req,
	stg_rsp_if.source rsp
);
	import stg_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    in_ready;

	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;

	// sequencer: one item in flight, walks read / execute / write steps
	stg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// column memory, phase word, decode and result register
	stg_datapath #(
		.MAX_QUBITS (MAX_QUBITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg.valid),
		.cfg_data      (cfg.qubits_in_use),
		.kind          (req.kind),
		.target_qubit  (req.target_qubit),
		.control_qubit (req.control_qubit),
		.column_select (req.column_select),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.read_data     (rsp.read_data),
		.error         (rsp.error)
	);

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for stabilizer_tableau_gate_engine_top: directed and random gate
// items against an in-bench tableau predictor. Depends on stg_pkg and stg_channels.
module tb;
	import stg_pkg::*;

	localparam int unsigned MAX_Q         = 32;
	localparam int unsigned N_COLS        = 64;
	localparam int unsigned HOLD_CYCLES   = 300;  // long output stall
	localparam int unsigned WATCHDOG_MAX  = 2000; // cycles with no handshake at all
	localparam int unsigned SETTLE_CYCLES = 20;   // tail after the last result
	// kinds above KIND_READ_PHASE are undefined and must be rejected
	localparam logic [KIND_W-1:0] KIND_UNDEF_TOP = {KIND_W{1'b1}};

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [QUBIT_W-1:0] tq;
		logic [QUBIT_W-1:0] cq;
		logic [SEL_W-1:0]   sel;
	} gate_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] data;
		logic             err;
	} tableau_result_t;

	logic clk = 1'b0;
	logic arst_n;

	stg_cfg_if cfg_ch();
	stg_req_if req_ch();
	stg_rsp_if rsp_ch();

	stabilizer_tableau_gate_engine_top #(
		.MAX_QUBITS(MAX_Q)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// Predicted device state: column words, phase word and the qubit count register.
	logic [ROW_W-1:0] col_word [N_COLS];
	logic [ROW_W-1:0] phase_word;
	logic [NQ_W-1:0]  qubit_reg;

	tableau_result_t expected_results[$];
	tableau_result_t exp_r;

	int unsigned fail_count  = 0;
	int unsigned items_sent  = 0;
	int unsigned results_seen = 0;
	int unsigned cfg_writes  = 0;
	int unsigned idle_cycles = 0;

	bit gaps_on       = 1'b1; // random gaps before request items
	bit stalls_on     = 1'b1; // random ready drops on the result side
	bit long_hold_req = 1'b0; // one-shot request for the long output stall

	// ---------------------------------------------------------------------
	// Tableau predictor
	// ---------------------------------------------------------------------
	function automatic void load_identity();
		for (int i = 0; i < N_COLS; i++)
			col_word[i] = {{(ROW_W-1){1'b0}}, 1'b1} << i;
		phase_word = '0;
	endfunction

	// register value clamped into 1..MAX_Q
	function automatic int unsigned active_qubits();
		int unsigned n;
		n = 32'(qubit_reg);
		if (n == 0)
			n = 1;
		if (n > MAX_Q)
			n = MAX_Q;
		return n;
	endfunction

	function automatic tableau_result_t apply_gate_item(gate_item_t it);
		int unsigned n, xt, zt, xc, zc;
		logic [ROW_W-1:0] xw, zw, xcw, zcw;
		tableau_result_t r;
		n = active_qubits();
		r = '0;
		case (it.kind)
			KIND_INIT: load_identity();
			KIND_X, KIND_Y, KIND_Z, KIND_S, KIND_SDAG, KIND_H, KIND_CNOT: begin
				if (it.tq >= n || (it.kind == KIND_CNOT && (it.cq >= n || it.cq == it.tq))) begin
					r.err = 1'b1;
				end else begin
					xt = 32'(it.tq);
					zt = 32'(it.tq) + n;
					xw = col_word[xt];
					zw = col_word[zt];
					case (it.kind)
						KIND_X: phase_word ^= zw;
						KIND_Y: phase_word ^= zw ^ xw;
						KIND_Z: phase_word ^= xw;
						KIND_S: begin
							phase_word ^= xw & zw;
							col_word[zt] = zw ^ xw;
						end
						KIND_SDAG: begin
							phase_word ^= xw & ~zw;
							col_word[zt] = zw ^ xw;
						end
						KIND_H: begin
							phase_word ^= xw & zw;
							col_word[xt] = zw;
							col_word[zt] = xw;
						end
						default: begin
							// CNOT: control columns picked up after the target words
							xc = 32'(it.cq);
							zc = 32'(it.cq) + n;
							xcw = col_word[xc];
							zcw = col_word[zc];
							phase_word ^= xcw & zw & ~(xw ^ zcw);
							col_word[xt] = xw ^ xcw;
							col_word[zc] = zcw ^ zw;
						end
					endcase
				end
			end
			KIND_READ_COL: begin
				if (it.sel >= 2 * n)
					r.err = 1'b1;
				else
					r.data = col_word[it.sel];
			end
			KIND_READ_PHASE: r.data = phase_word;
			default: r.err = 1'b1;
		endcase
		return r;
	endfunction

	function automatic gate_item_t gate_item(logic [KIND_W-1:0] k, int unsigned t, int unsigned c,
			int unsigned s);
		gate_item_t it;
		it.kind = k;
		it.tq   = t[QUBIT_W-1:0];
		it.cq   = c[QUBIT_W-1:0];
		it.sel  = s[SEL_W-1:0];
		return it;
	endfunction

	// ---------------------------------------------------------------------
	// Request side: one item per call, predicted at the accepting edge
	// ---------------------------------------------------------------------
	task automatic send_item(input gate_item_t it);
		tableau_result_t r;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.kind          <= it.kind;
		req_ch.target_qubit  <= it.tq;
		req_ch.control_qubit <= it.cq;
		req_ch.column_select <= it.sel;
		do @(posedge clk); while (!req_ch.ready);
		r = apply_gate_item(it);
		expected_results.insert(expected_results.size(), r);
		items_sent++;
	endtask

	// Mostly legal gates and in-range reads so the tableau wanders far from
	// identity; a few inits, undefined kinds and out-of-range indices mixed in.
	task automatic send_random_item();
		int unsigned n, pick, t, c, s;
		logic [KIND_W-1:0] k;
		n = active_qubits();
		pick = $urandom_range(0, 99);
		t = ($urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 31);
		s = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 2 * n - 1) : $urandom_range(0, 63);
		c = $urandom_range(0, 31);
		if (pick < 3)
			k = KIND_INIT;
		else if (pick < 6)
			k = KIND_W'($urandom_range(int'(KIND_READ_PHASE) + 1, int'(KIND_UNDEF_TOP)));
		else if (pick < 72)
			k = KIND_W'($urandom_range(int'(KIND_X), int'(KIND_CNOT)));
		else if (pick < 92)
			k = KIND_READ_COL;
		else
			k = KIND_READ_PHASE;
		// well-formed CNOT: distinct control inside the active range
		if (k == KIND_CNOT && n > 1 && t < n && $urandom_range(0, 9) != 0) begin
			c = $urandom_range(0, n - 2);
			if (c >= t)
				c++;
		end
		send_item(gate_item(k, t, c, s));
	endtask

	// Drop valid and wait until every predicted result has been checked.
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the engine idle.
	task automatic write_qubit_count(input int unsigned value);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.qubits_in_use <= value[NQ_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		qubit_reg = value[NQ_W-1:0];
		cfg_writes++;
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset-state reads, each gate at least once (X, Y, H and CNOT on the edge qubits),
	// CNOT with equal qubits, an undefined kind and init, all at the reset count of 32.
	task automatic test_directed_gates();
		send_item(gate_item(KIND_READ_COL, 0, 0, 0));
		send_item(gate_item(KIND_READ_COL, 0, 0, 63));
		send_item(gate_item(KIND_X, 0, 0, 0));
		send_item(gate_item(KIND_Y, 31, 0, 0));
		send_item(gate_item(KIND_Z, 5, 31, 0));
		send_item(gate_item(KIND_S, 1, 0, 0));
		send_item(gate_item(KIND_SDAG, 2, 0, 0));
		send_item(gate_item(KIND_H, 31, 0, 0));
		send_item(gate_item(KIND_CNOT, 0, 31, 0));
		send_item(gate_item(KIND_CNOT, 7, 7, 0));
		send_item(gate_item(KIND_READ_COL, 0, 0, 32));
		send_item(gate_item(KIND_READ_COL, 0, 0, 31));
		send_item(gate_item(KIND_READ_PHASE, 0, 0, 0));
		send_item(gate_item(KIND_UNDEF_TOP, 31, 31, 63));
		send_item(gate_item(KIND_INIT, 0, 0, 0));
		send_item(gate_item(KIND_H, 0, 0, 0));
		send_item(gate_item(KIND_S, 0, 0, 0));
		send_item(gate_item(KIND_READ_PHASE, 0, 0, 0));
	endtask

	// Count register extremes: zero acts as one qubit, above 32 clamps to 32;
	// the tableau is kept across writes until an init.
	task automatic test_qubit_count_edges();
		wait_for_drain();
		write_qubit_count(0);
		send_item(gate_item(KIND_X, 1, 0, 0));
		send_item(gate_item(KIND_H, 0, 0, 0));
		send_item(gate_item(KIND_READ_COL, 0, 0, 1));
		send_item(gate_item(KIND_READ_COL, 0, 0, 2));
		send_item(gate_item(KIND_CNOT, 0, 0, 0));
		send_item(gate_item(KIND_CNOT, 0, 1, 0));
		wait_for_drain();
		write_qubit_count(63);
		send_item(gate_item(KIND_H, 31, 0, 0));
		send_item(gate_item(KIND_READ_COL, 0, 0, 63));
		wait_for_drain();
		write_qubit_count(33);
		send_item(gate_item(KIND_READ_COL, 0, 0, 40));
		send_item(gate_item(KIND_INIT, 0, 0, 0));
	endtask

	// Fresh tableau at a given size, then a long random gate sequence.
	task automatic test_random_circuit(input int unsigned qubits, input int unsigned count);
		wait_for_drain();
		write_qubit_count(qubits);
		send_item(gate_item(KIND_INIT, 0, 0, 0));
		repeat (count) send_random_item();
	endtask

	// Result side holds off while items keep coming, so the engine backs up
	// into its input; then the sender waits for everything to come back.
	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		long_hold_req = 1'b1;
		repeat (40) send_random_item();
		gaps_on = 1'b1;
		wait_for_drain();
	endtask

	// Back-to-back items: valid held high on the request side, ready held high on the result side.
	task automatic test_full_rate(input int unsigned count);
		wait_for_drain();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		write_qubit_count(32);
		send_item(gate_item(KIND_INIT, 0, 0, 0));
		repeat (count) send_random_item();
		req_ch.valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Result side: random stall bursts plus the one long hold
	// ---------------------------------------------------------------------
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result with nothing pending: read_data %h error %b",
					rsp_ch.read_data, rsp_ch.error);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp_ch.read_data !== exp_r.data) begin
					$error("read_data: expected %h actual %h", exp_r.data, rsp_ch.read_data);
					fail_count++;
				end
				if (rsp_ch.error !== exp_r.err) begin
					$error("error: expected %b actual %b", exp_r.err, rsp_ch.error);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: any handshake on any channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("timeout: no handshake for %0d cycles, %0d results pending",
					idle_cycles, expected_results.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.kind          <= KIND_INIT;
		req_ch.target_qubit  <= '0;
		req_ch.control_qubit <= '0;
		req_ch.column_select <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.qubits_in_use <= '0;
		load_identity();
		qubit_reg = MAX_Q;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_gates();
		test_qubit_count_edges();
		test_random_circuit(32, 160);
		test_random_circuit(3, 120);
		test_output_backpressure();
		test_random_circuit(17, 140);
		test_random_circuit(2, 100);
		test_random_circuit($urandom_range(1, 32), 120);
		test_full_rate(120);

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items, checked %0d results, %0d qubit-count writes.",
			items_sent, results_seen, cfg_writes);
		$display("Covered all gate kinds, bad indices, count clamping, long stall, full rate.");
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/stg_pkg.sv
rtl/stg_channels.sv
rtl/stg_datapath.sv
rtl/stg_ctrl.sv
rtl/stabilizer_tableau_gate_engine_top.sv
tb/sv/tb.sv
